@@ hw/rtl/qs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qs_pkg
// shared types and constants of the quaternion slerp pipeline
// ----------------------------------------------------------------------------
package qs_pkg;

    // floor(atan(2^-i) * 2^30)
    localparam logic [30:0] ATAN_TAB [0:31] = '{
        31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158,
        31'd67021686,  31'd33543515,  31'd16775850,  31'd8388437,
        31'd4194282,   31'd2097149,   31'd1048575,   31'd524287,
        31'd262143,    31'd131071,    31'd65535,     31'd32767,
        31'd16383,     31'd8191,      31'd4095,      31'd2047,
        31'd1023,      31'd511,       31'd255,       31'd127,
        31'd63,        31'd31,        31'd15,        31'd7,
        31'd3,         31'd1,         31'd0,         31'd0
    };

    localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
    localparam logic [30:0] THR_RESET    = 31'd1073634450;
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
    localparam logic [16:0] T_ONE        = 17'd65536;

    typedef struct packed {
        logic signed [31:0] a_w;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic        [16:0] fraction;
    } item_t;

    typedef struct packed {
        logic signed [31:0] r_w;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
    } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/qs_stream_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qs_stream_if
// valid/ready channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface qs_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/qs_sqrt_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qs_sqrt_cell
// one radix-4 step of the integer square root, registered
// ----------------------------------------------------------------------------
module qs_sqrt_cell #(
    parameter int K = 0
) (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [60:0] rem_i,
    input  wire logic [61:0] res_i,
    output logic      [60:0] rem_o,
    output logic      [61:0] res_o
);
    localparam logic [61:0] BIT = 62'd1 << (2 * K);

    logic [61:0] trial;
    logic        ge;
    logic [60:0] rem_next;
    logic [61:0] res_next;
    logic [60:0] rem_reg;
    logic [61:0] res_reg;

    always_comb
    begin
        trial    = res_i + BIT;
        ge       = {1'b0, rem_i} >= trial;
        rem_next = ge ? (rem_i - trial[60:0]) : rem_i;
        res_next = ge ? ((res_i >> 1) + BIT) : (res_i >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
        end
    end

    assign rem_o = rem_reg;
    assign res_o = res_reg;
endmodule
`default_nettype wire

@@ hw/rtl/qs_cordic_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qs_cordic_cell
// one cordic micro-rotation, vectoring or rotation mode, registered
// ----------------------------------------------------------------------------
module qs_cordic_cell #(
    parameter int SHIFT     = 0,
    parameter int XW        = 34,
    parameter int ZW        = 34,
    parameter bit VECTORING = 1'b1
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [XW-1:0] x_i,
    input  wire logic signed [XW-1:0] y_i,
    input  wire logic signed [ZW-1:0] z_i,
    output logic signed      [XW-1:0] x_o,
    output logic signed      [XW-1:0] y_o,
    output logic signed      [ZW-1:0] z_o
);
    localparam logic signed [ZW-1:0] ATAN =
        $signed({{(ZW-31){1'b0}}, qs_pkg::ATAN_TAB[SHIFT]});

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 up;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;

    always_comb
    begin
        dx = y_i >>> SHIFT;
        dy = x_i >>> SHIFT;
        // vectoring drives y to zero, rotation drives z to zero
        up = VECTORING ? (y_i > 0) : z_i[ZW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (up)
            begin
                x_reg <= x_i + dx;
                y_reg <= y_i - dy;
                z_reg <= z_i + ATAN;
            end
            else
            begin
                x_reg <= x_i - dx;
                y_reg <= y_i + dy;
                z_reg <= z_i - ATAN;
            end
        end
    end

    assign x_o = x_reg;
    assign y_o = y_reg;
    assign z_o = z_reg;
endmodule
`default_nettype wire

@@ hw/rtl/qs_div_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qs_div_cell
// one restoring division step, one quotient bit, registered
// ----------------------------------------------------------------------------
module qs_div_cell (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [30:0] rem_i,
    input  wire logic [29:0] quo_i,
    input  wire logic        sat_i,
    input  wire logic [30:0] dvs_i,
    output logic      [30:0] rem_o,
    output logic      [29:0] quo_o,
    output logic             sat_o
);
    logic [31:0] rem2;
    logic        ge;
    logic [30:0] rem_next;
    logic [30:0] rem_reg;
    logic [29:0] quo_reg;
    logic        sat_reg;

    always_comb
    begin
        rem2     = {rem_i, 1'b0};
        ge       = rem2 >= {1'b0, dvs_i};
        rem_next = ge ? 31'(rem2 - {1'b0, dvs_i}) : rem2[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_i[28:0], ge};
            sat_reg <= sat_i;
        end
    end

    assign rem_o = rem_reg;
    assign quo_o = quo_reg;
    assign sat_o = sat_reg;
endmodule
`default_nettype wire

@@ hw/rtl/quaternion_slerp_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_slerp_top
// fully pipelined spherical linear interpolation of two quaternions
// ----------------------------------------------------------------------------
// One quaternion pair is taken and one result leaves per clock unless the
// result channel stalls. Depth is set by the chain: 31 square-root cells,
// a vectoring cordic row and two parallel rotation rows of TRIG_ITERATIONS
// cells each, 30 divider cells per lane, and registered stages for the input
// products, dot product, radicand, angle scaling and blend. The whole chain
// advances together whenever the output register is empty or being taken, so
// a stalled result holds the pipeline without losing any item. The threshold
// register should only be written while no item is in flight.
module quaternion_slerp_top #(
    parameter int TRIG_ITERATIONS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [30:0] cfg_wdata,
    qs_stream_if.sink        item,
    qs_stream_if.source      result
);
    localparam int N         = TRIG_ITERATIONS;
    localparam int SQ_STEPS  = 31;
    localparam int DIV_STEPS = 30;
    localparam int XW        = 34;
    localparam int ZA        = 34;
    localparam int ZS        = 51;
    // sideband index at which each segment of the chain finishes
    localparam int SQ_END    = 1 + SQ_STEPS;
    localparam int AT_END    = SQ_END + N;
    localparam int MU        = AT_END + 1;
    localparam int PA        = MU + 1;
    localparam int SN_END    = PA + N;
    localparam int DV_END    = SN_END + DIV_STEPS;

    typedef struct packed {
        logic [3:0][31:0] a;
        logic [3:0][31:0] b;
        logic [16:0]      t;
        logic             flip;
        logic             lin;
        logic [30:0]      c;
        logic [30:0]      s;
    } side_t;

    // handshake and control
    logic        adv;
    logic [30:0] thr_reg;
    logic        v0_reg;
    logic        vld_reg [0:DV_END];
    logic        fp_vld_reg;
    logic        out_valid_reg;

    // input stage
    logic signed [31:0] ia [4];
    logic signed [31:0] ib [4];
    logic signed [31:0] a0_reg [4];
    logic signed [31:0] b0_reg [4];
    logic        [16:0] t0_reg;
    logic signed [63:0] prod_reg [4];

    // dot product and sideband line
    logic signed [63:0] acc;
    logic signed [63:0] c_raw;
    logic signed [63:0] mag;
    side_t              side0;
    side_t              side_next [0:DV_END];
    side_t              side_reg [0:DV_END];
    logic        [61:0] csq;
    logic        [60:0] n_reg;

    // square root chain
    logic [60:0] sq_rem [0:SQ_STEPS];
    logic [61:0] sq_res [0:SQ_STEPS];

    // angle chain
    logic signed [XW-1:0] at_x [0:N];
    logic signed [XW-1:0] at_y [0:N];
    logic signed [ZA-1:0] at_z [0:N];

    // angle scaling
    logic        [16:0] ta_mu;
    logic signed [51:0] pp_reg [2];
    logic signed [51:0] pp_sh [2];
    logic        [50:0] pp_off [2];
    logic signed [ZS-1:0] z_reg [2];

    // sine chains and dividers, lane 0 weights a and lane 1 weights b
    logic signed [XW-1:0] sx [0:1][0:N];
    logic signed [XW-1:0] sy [0:1][0:N];
    logic signed [ZS-1:0] sz [0:1][0:N];
    logic        [30:0]   sn [2];
    logic [30:0] d_rem [0:1][0:DIV_STEPS];
    logic [29:0] d_quo [0:1][0:DIV_STEPS];
    logic        d_sat [0:1][0:DIV_STEPS];

    // blend
    logic        [16:0] ta_f;
    logic               lin_use;
    logic signed [31:0] wsph [2];
    logic signed [31:0] wa;
    logic signed [31:0] wb;
    logic signed [63:0] fa_reg [4];
    logic signed [63:0] fb_reg [4];
    logic signed [64:0] sum [4];
    logic signed [64:0] rnd [4];
    logic signed [31:0] r_next [4];
    logic signed [31:0] r_reg [4];

    // the whole chain moves on when the output register can take a transfer
    assign adv        = !out_valid_reg || result.ready;
    assign item.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= qs_pkg::THR_RESET;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            fp_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j <= DV_END; j++)
                vld_reg[j] <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg        <= item.valid;
            vld_reg[0]    <= v0_reg;
            for (int j = 1; j <= DV_END; j++)
                vld_reg[j] <= vld_reg[j-1];
            fp_vld_reg    <= vld_reg[DV_END];
            out_valid_reg <= fp_vld_reg;
        end
    end

    // input stage: four component products
    always_comb
    begin
        ia[0] = item.data.a_w;
        ia[1] = item.data.a_x;
        ia[2] = item.data.a_y;
        ia[3] = item.data.a_z;
        ib[0] = item.data.b_w;
        ib[1] = item.data.b_x;
        ib[2] = item.data.b_y;
        ib[3] = item.data.b_z;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                a0_reg[i]   <= ia[i];
                b0_reg[i]   <= ib[i];
                prod_reg[i] <= ia[i] * ib[i];
            end
            t0_reg <= item.data.fraction;
        end
    end

    // dot product, sign fold, clamp and threshold test
    always_comb
    begin
        acc   = (prod_reg[0] >>> 2) + (prod_reg[1] >>> 2)
              + (prod_reg[2] >>> 2) + (prod_reg[3] >>> 2);
        c_raw = acc >>> 28;
        mag   = acc[63] ? -c_raw : c_raw;
        for (int i = 0; i < 4; i++)
        begin
            side0.a[i] = a0_reg[i];
            side0.b[i] = b0_reg[i];
        end
        side0.t    = (t0_reg > qs_pkg::T_ONE) ? qs_pkg::T_ONE : t0_reg;
        side0.flip = acc[63];
        side0.c    = (mag > 64'sh4000_0000) ? qs_pkg::ONE_Q30 : mag[30:0];
        side0.lin  = side0.c > thr_reg;
        side0.s    = '0;
    end

    // sideband line, the sine of the angle joins once the root is ready
    always_comb
    begin
        side_next[0] = side0;
        for (int j = 1; j <= DV_END; j++)
        begin
            side_next[j] = side_reg[j-1];
            if (j == SQ_END + 1)
                side_next[j].s = sq_res[SQ_STEPS][30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j <= DV_END; j++)
                side_reg[j] <= side_next[j];
        end
    end

    // radicand 1 - c^2
    assign csq = side_reg[0].c * side_reg[0].c;

    always_ff @(posedge clk)
    begin
        if (adv)
            n_reg <= 61'((62'd1 << 60) - csq);
    end

    // square root chain
    assign sq_rem[0] = n_reg;
    assign sq_res[0] = '0;

    for (genvar m = 0; m < SQ_STEPS; m++)
    begin : g_sqrt
        qs_sqrt_cell #(
            .K (SQ_STEPS - 1 - m)
        ) u_cell (
            .clk   (clk),
            .en    (adv),
            .rem_i (sq_rem[m]),
            .res_i (sq_res[m]),
            .rem_o (sq_rem[m+1]),
            .res_o (sq_res[m+1])
        );
    end

    // theta = atan2(s, c) by vectoring
    assign at_x[0] = $signed({3'b000, side_reg[SQ_END].c});
    assign at_y[0] = $signed({3'b000, sq_res[SQ_STEPS][30:0]});
    assign at_z[0] = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_atan
        qs_cordic_cell #(
            .SHIFT     (i),
            .XW        (XW),
            .ZW        (ZA),
            .VECTORING (1'b1)
        ) u_cell (
            .clk (clk),
            .en  (adv),
            .x_i (at_x[i]),
            .y_i (at_y[i]),
            .z_i (at_z[i]),
            .x_o (at_x[i+1]),
            .y_o (at_y[i+1]),
            .z_o (at_z[i+1])
        );
    end

    // scaled angles (1-t)theta and t theta
    assign ta_mu = 17'(qs_pkg::T_ONE - side_reg[AT_END].t);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_reg[0] <= $signed({1'b0, ta_mu}) * at_z[N];
            pp_reg[1] <= $signed({1'b0, side_reg[AT_END].t}) * at_z[N];
        end
    end

    // a negative product wraps as an unsigned 64-bit value before the shift
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            pp_sh[l]  = pp_reg[l] >>> 16;
            pp_off[l] = {2'b00, pp_reg[l][51], 48'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 2; l++)
                z_reg[l] <= $signed(pp_sh[l][50:0] + pp_off[l]);
        end
    end

    // sine rows, then division by s
    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        assign sx[l][0] = $signed({4'b0000, qs_pkg::INV_GAIN_Q30});
        assign sy[l][0] = '0;
        assign sz[l][0] = z_reg[l];

        for (genvar i = 0; i < N; i++)
        begin : g_sin
            qs_cordic_cell #(
                .SHIFT     (i),
                .XW        (XW),
                .ZW        (ZS),
                .VECTORING (1'b0)
            ) u_cell (
                .clk (clk),
                .en  (adv),
                .x_i (sx[l][i]),
                .y_i (sy[l][i]),
                .z_i (sz[l][i]),
                .x_o (sx[l][i+1]),
                .y_o (sy[l][i+1]),
                .z_o (sz[l][i+1])
            );
        end

        // clamp the sine to [0, 1]; a sine not below s saturates the weight
        assign sn[l] = sy[l][N][XW-1] ? 31'd0 :
                       (sy[l][N] > $signed(34'h0_4000_0000)) ? qs_pkg::ONE_Q30 :
                       sy[l][N][30:0];
        assign d_rem[l][0] = sn[l];
        assign d_quo[l][0] = '0;
        assign d_sat[l][0] = sn[l] >= side_reg[SN_END].s;

        for (genvar d = 0; d < DIV_STEPS; d++)
        begin : g_div
            qs_div_cell u_cell (
                .clk   (clk),
                .en    (adv),
                .rem_i (d_rem[l][d]),
                .quo_i (d_quo[l][d]),
                .sat_i (d_sat[l][d]),
                .dvs_i (side_reg[SN_END+d].s),
                .rem_o (d_rem[l][d+1]),
                .quo_o (d_quo[l][d+1]),
                .sat_o (d_sat[l][d+1])
            );
        end

        assign wsph[l] = d_sat[l][DIV_STEPS] ? 32'sh4000_0000 :
                         $signed({2'b00, d_quo[l][DIV_STEPS]});
    end

    // weight selection and the eight blend products
    always_comb
    begin
        ta_f    = 17'(qs_pkg::T_ONE - side_reg[DV_END].t);
        // linear weights when nearly equal or when the sine vanishes
        lin_use = side_reg[DV_END].lin || (side_reg[DV_END].s == 31'd0);
        wa      = lin_use ? $signed({1'b0, ta_f, 14'd0}) : wsph[0];
        wb      = lin_use ? $signed({1'b0, side_reg[DV_END].t, 14'd0}) : wsph[1];
        if (side_reg[DV_END].flip)
            wa = -wa;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                fa_reg[i] <= wa * $signed(side_reg[DV_END].a[i]);
                fb_reg[i] <= wb * $signed(side_reg[DV_END].b[i]);
            end
        end
    end

    // round half up and saturate
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sum[i] = $signed({fa_reg[i][63], fa_reg[i]})
                   + $signed({fb_reg[i][63], fb_reg[i]})
                   + 65'sd536870912;
            rnd[i] = sum[i] >>> 30;
            if (rnd[i] > 65'sd2147483647)
                r_next[i] = 32'sh7fff_ffff;
            else if (rnd[i] < -65'sd2147483648)
                r_next[i] = 32'sh8000_0000;
            else
                r_next[i] = rnd[i][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
                r_reg[i] <= r_next[i];
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.data.r_w   = r_reg[0];
    assign result.data.r_x   = r_reg[1];
    assign result.data.r_y   = r_reg[2];
    assign result.data.r_z   = r_reg[3];

`ifndef SYNTH
    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> v0_reg)
        else $error("accepted transfer did not enter the chain");

    a_root_range : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SQ_END] |-> (sq_res[SQ_STEPS] <= 62'h4000_0000))
        else $error("square root above one");

    a_weight_range : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DV_END] && !lin_use |->
            (wsph[0] <= 32'sh4000_0000) && (wsph[1] <= 32'sh4000_0000))
        else $error("spherical weight above one");

    a_result_lands : assert property (@(posedge clk) disable iff (!rst_n)
        fp_vld_reg && adv |=> out_valid_reg)
        else $error("blended item lost before the output register");
`endif
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// quaternion slerp testbench
// Random and directed quaternion pairs are driven into the pipeline, with
// random gaps on both channels and one long output stall. Each result is
// compared with a bit-exact fixed-point prediction made when its input
// transfer happens. The threshold register is rewritten between phases,
// only while the pipeline is drained.
// ----------------------------------------------------------------------------
module testbench;

    typedef longint unsigned u64_t;

    function automatic int TRIG_ITER_CLAMP(int n);
        return (n > 32) ? 32 : ((n < 0) ? 0 : n);
    endfunction

    localparam int  ITER        = (TRIG_ITER_CLAMP(24));
    localparam int  LATENCY     = 2 * 24 + 67;
    localparam int  DRAIN_WAIT  = LATENCY + 20;
    localparam int  QUIET_LIMIT = 6000;
    localparam longint ONE      = 64'sd1073741824;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [30:0] cfg_wdata;

    qs_stream_if #(.payload_t(qs_pkg::item_t))   item_ch ();
    qs_stream_if #(.payload_t(qs_pkg::result_t)) result_ch ();

    quaternion_slerp_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch.sink),
        .result    (result_ch.source)
    );

    // threshold as the block should hold it
    logic [30:0] threshold_copy;

    qs_pkg::item_t   pending_pairs[$];
    qs_pkg::result_t expected_quats[$];
    int      error_count;
    int      results_seen;
    bit      item_taken;

    // ------------------------------------------------------------------------
    // fixed-point slerp predictor
    // ------------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // vectoring rotation: angle of (x, y)
    function automatic longint angle_of(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < ITER; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += longint'(qs_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x -= dx; y += dy; z -= longint'(qs_pkg::ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic longint sine_of(longint z);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = longint'(qs_pkg::INV_GAIN_Q30);
        y = 0;
        for (int i = 0; i < ITER; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(qs_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x += dx; y -= dy; z += longint'(qs_pkg::ATAN_TAB[i]);
            end
        end
        if (y < 0) y = 0;
        if (y > ONE) y = ONE;
        return y;
    endfunction

    function automatic longint sphere_weight(longint sn, longint s);
        u64_t w;
        w = (u64_t'(sn) << 30) / u64_t'(s);
        if (w > u64_t'(ONE)) w = u64_t'(ONE);
        return longint'(w);
    endfunction

    function automatic qs_pkg::result_t slerp_predict(qs_pkg::item_t it, logic [30:0] thr);
        longint a[4];
        longint b[4];
        longint acc;
        longint c;
        longint wa;
        longint wb;
        longint s;
        longint theta;
        longint pa;
        longint pb;
        longint r;
        longint t;
        bit     flip;
        logic signed [31:0] outv[4];
        qs_pkg::result_t res;
        a = '{longint'(it.a_w), longint'(it.a_x), longint'(it.a_y), longint'(it.a_z)};
        b = '{longint'(it.b_w), longint'(it.b_x), longint'(it.b_y), longint'(it.b_z)};
        t = longint'({47'd0, it.fraction});
        if (t > 65536) t = 65536;
        acc = 0;
        for (int i = 0; i < 4; i++)
            acc += (a[i] * b[i]) >>> 2;
        c = acc >>> 28;
        flip = 0;
        if (c < 0)
        begin
            c = -c;
            flip = 1;
        end
        if (c > ONE) c = ONE;
        wa = (65536 - t) << 14;
        wb = t << 14;
        if (c <= longint'({33'd0, thr}))
        begin
            s = longint'(int_sqrt(u64_t'(ONE * ONE - c * c)));
            // zero sine keeps the linear weights
            if (s != 0)
            begin
                theta = angle_of(s, c);
                // angle scaling is done in unsigned 64-bit arithmetic
                pa = longint'((u64_t'(65536 - t) * u64_t'(theta)) >> 16);
                pb = longint'((u64_t'(t) * u64_t'(theta)) >> 16);
                wa = sphere_weight(sine_of(pa), s);
                wb = sphere_weight(sine_of(pb), s);
            end
        end
        if (flip) wa = -wa;
        for (int i = 0; i < 4; i++)
        begin
            r = (wa * a[i] + wb * b[i] + (64'sd1 << 29)) >>> 30;
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            outv[i] = r[31:0];
        end
        res.r_w = outv[0];
        res.r_x = outv[1];
        res.r_y = outv[2];
        res.r_z = outv[3];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // gap length: mostly none, some short, a few long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // input driver: offers the queued pairs, changes at the falling edge
    // ------------------------------------------------------------------------
    int send_gap;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_ch.data  <= '0;
            send_gap = 0;
        end
        else if (item_ch.valid && !item_taken)
        begin
            // hold the offered pair until its transfer
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            item_ch.valid <= 1'b0;
        end
        else if (pending_pairs.size() != 0)
        begin
            item_ch.data  <= pending_pairs.pop_front();
            item_ch.valid <= 1'b1;
            send_gap = gap_len();
        end
        else
        begin
            item_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // output side ready: random gaps plus one long hold-off once the stream
    // is running, so the pipeline fills and stalls the input
    // ------------------------------------------------------------------------
    int  stall_left;
    bit  long_stall_done;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
            long_stall_done = 0;
        end
        else
        begin
            if (!long_stall_done && results_seen >= 60)
            begin
                long_stall_done = 1;
                stall_left = 400;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                stall_left = gap_len();
                result_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on each input transfer, checks each output transfer
    // ------------------------------------------------------------------------
    qs_pkg::result_t got;
    qs_pkg::result_t want;

    always @(posedge clk)
    begin
        item_taken = rst_n && item_ch.valid && item_ch.ready;
        if (cfg_we)
            threshold_copy = cfg_wdata;
        if (item_taken)
            expected_quats.push_back(slerp_predict(item_ch.data, threshold_copy));
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            results_seen++;
            if (expected_quats.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d",
                         $time, got.r_w, got.r_x, got.r_y, got.r_z);
            end
            else
            begin
                want = expected_quats.pop_front();
                if (got.r_w !== want.r_w)
                    $display("%0t: r_w expected %0d got %0d", $time, want.r_w, got.r_w);
                if (got.r_x !== want.r_x)
                    $display("%0t: r_x expected %0d got %0d", $time, want.r_x, got.r_x);
                if (got.r_y !== want.r_y)
                    $display("%0t: r_y expected %0d got %0d", $time, want.r_y, got.r_y);
                if (got.r_z !== want.r_z)
                    $display("%0t: r_z expected %0d got %0d", $time, want.r_z, got.r_z);
                if (got !== want)
                    error_count++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles with no transfer on either channel
    // ------------------------------------------------------------------------
    int quiet_cycles;

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[quaternion_slerp_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [31:0] rand_word();
        return $urandom();
    endfunction

    // fraction mostly in range, sometimes above one so that bit 16 toggles
    function automatic logic [16:0] rand_fraction();
        int p;
        p = $urandom_range(0, 99);
        if (p < 5) return 17'd0;
        if (p < 10) return qs_pkg::T_ONE;
        if (p < 20) return 17'($urandom_range(0, 131071));
        return 17'($urandom_range(0, 65536));
    endfunction

    // random direction in 4-space scaled to the given magnitude
    task automatic rand_quat(input real mag, output logic signed [31:0] q[4]);
        real v[4];
        real n;
        n = 0.0;
        while (n < 1.0e-3)
        begin
            for (int i = 0; i < 4; i++)
                v[i] = ($itor($urandom_range(0, 2000000)) - 1000000.0) / 1000000.0;
            n = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2] + v[3] * v[3]);
        end
        for (int i = 0; i < 4; i++)
            q[i] = $rtoi(v[i] / n * mag * 1073741824.0);
    endtask

    task automatic push_pair(input logic signed [31:0] qa[4],
                             input logic signed [31:0] qb[4],
                             input logic [16:0] frac);
        qs_pkg::item_t it;
        it.a_w = qa[0]; it.a_x = qa[1]; it.a_y = qa[2]; it.a_z = qa[3];
        it.b_w = qb[0]; it.b_x = qb[1]; it.b_y = qb[2]; it.b_z = qb[3];
        it.fraction = frac;
        pending_pairs.push_back(it);
    endtask

    task automatic push_random(int count);
        logic signed [31:0] qa[4];
        logic signed [31:0] qb[4];
        int kind;
        for (int k = 0; k < count; k++)
        begin
            kind = $urandom_range(0, 99);
            rand_quat(0.9999, qa);
            if (kind < 40)
            begin
                rand_quat(0.9999, qb);
            end
            else if (kind < 60)
            begin
                // nearly equal or nearly opposite pair, around the threshold
                for (int i = 0; i < 4; i++)
                    qb[i] = qa[i] + $signed($urandom_range(0, 2 ** ($urandom_range(4, 22))))
                            - $signed($urandom_range(0, 2 ** ($urandom_range(4, 22))));
                if ($urandom_range(0, 1))
                    for (int i = 0; i < 4; i++)
                        qb[i] = -qb[i];
            end
            else if (kind < 75)
            begin
                // non-unit quaternions, dot product may exceed one
                rand_quat(1.0 + $itor($urandom_range(0, 900)) / 1000.0, qa);
                rand_quat(1.0 + $itor($urandom_range(0, 900)) / 1000.0, qb);
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                begin
                    qa[i] = rand_word();
                    qb[i] = rand_word();
                end
            end
            push_pair(qa, qb, rand_fraction());
        end
    endtask

    // let the pipeline drain completely before touching the threshold
    task automatic wait_drained();
        while (pending_pairs.size() != 0 || item_ch.valid || expected_quats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [30:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] Q1   = 32'sh4000_0000;
    localparam logic signed [31:0] HALF = 32'sh2000_0000;

    initial
    begin
        logic signed [31:0] qa[4];
        logic signed [31:0] qb[4];
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        threshold_copy = qs_pkg::THR_RESET;
        error_count    = 0;
        results_seen   = 0;
        quiet_cycles   = 0;
        item_taken     = 0;
        @(posedge rst_n);

        // directed pairs at the reset threshold
        qa = '{Q1, 0, 0, 0};
        qb = '{0, Q1, 0, 0};
        push_pair(qa, qb, 17'd0);
        push_pair(qa, qb, qs_pkg::T_ONE);
        push_pair(qa, qb, 17'd32768);
        push_pair(qa, qb, 17'h1FFFF);           // fraction above one
        push_pair(qa, qa, 17'd12345);           // identical, linear blend
        qb = '{-Q1, 0, 0, 0};
        push_pair(qa, qb, 17'd20000);           // opposite, negative dot
        qb = '{HALF, HALF, HALF, HALF};
        push_pair(qa, qb, 17'd40000);
        qb = '{-HALF, HALF, -HALF, HALF};
        push_pair(qa, qb, 17'd1);
        qa = '{MAXV, MAXV, MAXV, MAXV};
        qb = '{MINV, MINV, MINV, MINV};
        push_pair(qa, qb, 17'd30000);           // dot clamps, saturation
        push_pair(qa, qa, 17'd65535);
        push_pair(qb, qb, 17'd100);
        qb = '{MAXV, MINV, MAXV, MINV};
        push_pair(qa, qb, 17'd50000);
        qa = '{0, 0, 0, 0};
        push_pair(qa, qa, 17'd33333);           // zero vectors
        push_pair(qa, qb, 17'd65536);
        qa = '{32'sd1073741000, 32'sd1000, 0, 0};
        qb = '{32'sd1073741000, -32'sd1000, 0, 0};
        push_pair(qa, qb, 17'd32768);           // just around the threshold
        qa = '{MINV, 0, 0, 0};
        qb = '{MINV, 0, 0, 0};
        push_pair(qa, qb, 17'd16384);
        push_random(320);
        wait_drained();

        // threshold zero: spherical path only where the folded cosine is zero
        write_threshold(31'd0);
        push_random(140);
        wait_drained();

        // threshold one: equal inputs hit the zero-sine fallback
        write_threshold(qs_pkg::ONE_Q30);
        qa = '{Q1, 0, 0, 0};
        push_pair(qa, qa, 17'd1000);
        qb = '{-Q1, 0, 0, 0};
        push_pair(qa, qb, 17'd60000);
        push_pair(qb, qb, 17'd0);
        push_random(140);
        wait_drained();

        // largest value: the threshold test never selects the linear blend
        write_threshold(31'h7FFF_FFFF);
        qa = '{MAXV, 0, 0, 0};
        push_pair(qa, qa, 17'd7);
        push_random(100);
        wait_drained();

        write_threshold(31'($urandom_range(0, 1073741824)));
        push_random(100);
        wait_drained();

        write_threshold(qs_pkg::THR_RESET);
        push_random(80);
        wait_drained();

        if (error_count == 0)
            $display("[quaternion_slerp_top] OK");
        else
            $display("[quaternion_slerp_top] ERROR");
        $finish;
    end

endmodule
